// ===== src/row_moving_average_core_macros.svh =====
// ----------------------------------------------------------------------------
// Row moving average - assertion macros
// Shorthand for clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ROW_MOVING_AVERAGE_CORE_MACROS_SVH
`define ROW_MOVING_AVERAGE_CORE_MACROS_SVH

// same-cycle implication
`define RMA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row moving average - package
// Field widths, beat types and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package rma_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int WL_BITS        = 6;
    localparam int SUM_BITS       = SAMPLE_BITS + WL_BITS;
    localparam int FILL_BITS      = 7;
    localparam int MAX_WINDOW_DEF = 63;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          row_end;
    } rma_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          row_last;
        logic                          last_of_run;
    } rma_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIV,
        ST_LOAD,
        ST_DROP
    } rma_state_t;

endpackage

// ===== src/rma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row moving average - simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 63
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rma_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row moving average - serial divider
// Restoring signed-by-unsigned division, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module rma_serial_div import rma_pkg::*; #(
    parameter int DW = SUM_BITS,
    parameter int VW = WL_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [VW-1:0]        divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic          neg_reg, neg_next;

    logic [VW:0]   shifted;
    logic [VW+1:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        neg_reg <= neg_next;
    end

    assign shifted = {rem_reg, dq_reg[DW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        neg_next  = neg_reg;
        if (start) begin
            neg_next  = dividend[DW-1];
            dq_next   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[VW+1]) begin
                rem_next = trial[VW-1:0];
                dq_next  = {dq_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[VW-1:0];
                dq_next  = {dq_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(dq_reg) : signed'(dq_reg);

endmodule

// ===== src/row_moving_average_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row moving average - top level
// Boxcar average along image rows with edge skipping and row-end flush.
// ----------------------------------------------------------------------------
// Each sample updates a running window sum (sample store in a RAM of
// MAX_WINDOW entries) and, once h = (window_length-1)/2 later samples have
// arrived, yields sum / window_length truncated toward zero. Each result
// comes from the bit-serial divider (one quotient bit per cycle over the
// SUM_BITS-wide sum). A row-end sample flushes up to h+1 results (fewer
// on a short row) and clears the row state. A result that waits for
// m_ready adds its stall. One sample is in work at a time; the next is
// taken while the last result still waits in the output register.
// window_length 0 acts as 1; values above MAX_WINDOW clamp to it. Writing
// window_length restarts the current row.
// ----------------------------------------------------------------------------
module row_moving_average_core import rma_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WL_BITS-1:0] cfg_window_length,
    input  logic               s_valid,
    output logic               s_ready,
    input  rma_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rma_out_t           m_data
);

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int AW     = ((SLOT_W > WL_BITS) ? SLOT_W : WL_BITS) + 1;
    localparam logic [AW-1:0] DEPTH_A = AW'(MAX_WINDOW);

    rma_state_t state_reg, state_next;

    logic [WL_BITS-1:0]            len_reg, len_next;
    logic [WL_BITS-1:0]            h_reg, h_next;
    logic [WL_BITS-1:0]            span_reg, span_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [FILL_BITS-1:0]          fill_reg, fill_next;
    logic [SLOT_W-1:0]             wr_reg, wr_next;
    logic [WL_BITS-1:0]            j_reg, j_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          end_reg, end_next;
    rma_out_t                      out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic                   in_beat;
    logic                   cfg_beat;
    logic                   out_free;
    logic [WL_BITS-1:0]     eff_len;
    logic [FILL_BITS-1:0]   fill_inc;
    logic                   drop_old;
    logic                   drop_run;
    logic [SLOT_W-1:0]      wr_inc;
    logic [WL_BITS-1:0]     run_cnt;

    logic                   ram_we;
    logic                   ram_re;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic                       div_start;
    logic                       div_done;
    logic signed [SUM_BITS-1:0] div_quot;

    function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0] wr,
                                                    input logic [WL_BITS-1:0] d);
        logic [AW-1:0] w;
        logic [AW-1:0] dd;
        w  = AW'(wr);
        dd = AW'(d);
        if (w >= dd) begin
            return SLOT_W'(w - dd);
        end
        return SLOT_W'(w + DEPTH_A - dd);
    endfunction

    rma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_reg),
        .wdata (x_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rma_serial_div #(
        .DW (SUM_BITS),
        .VW (WL_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= WL_BITS'(1);
            h_reg         <= '0;
            span_reg      <= WL_BITS'(1);
            sum_reg       <= '0;
            fill_reg      <= '0;
            wr_reg        <= '0;
            j_reg         <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            h_reg         <= h_next;
            span_reg      <= span_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            wr_reg        <= wr_next;
            j_reg         <= j_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    assign cfg_beat = cfg_valid && cfg_ready;
    assign in_beat  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        eff_len = (cfg_window_length == '0) ? WL_BITS'(1) : cfg_window_length;
        if (int'(eff_len) > MAX_WINDOW) begin
            eff_len = WL_BITS'(MAX_WINDOW);
        end
    end

    assign fill_inc = (fill_reg == '1) ? fill_reg : fill_reg + FILL_BITS'(1);
    assign drop_old = fill_reg >= FILL_BITS'(span_reg);
    assign drop_run = fill_reg >= FILL_BITS'(j_reg) + FILL_BITS'(h_reg) + FILL_BITS'(1);
    assign wr_inc   = (int'(wr_reg) == MAX_WINDOW - 1) ? '0 : wr_reg + SLOT_W'(1);
    assign run_cnt  = (fill_inc > FILL_BITS'(h_reg)) ? h_reg + WL_BITS'(1)
                                                     : WL_BITS'(fill_inc);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (end_reg || fill_inc > FILL_BITS'(h_reg)) begin
                    state_next = ST_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (!end_reg || j_reg == '0) begin
                        state_next = ST_IDLE;
                    end else if (drop_run) begin
                        state_next = ST_DROP;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_DROP: begin
                state_next = ST_START;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        len_next       = len_reg;
        h_next         = h_reg;
        span_next      = span_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        wr_next        = wr_reg;
        j_next         = j_reg;
        x_next         = x_reg;
        end_next       = end_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cfg_ready      = 1'b0;
        s_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = back_slot(wr_reg, span_reg);
        div_start      = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_beat) begin
                    len_next  = eff_len;
                    h_next    = (eff_len - WL_BITS'(1)) >> 1;
                    span_next = ((eff_len - WL_BITS'(1)) >> 1 << 1) | WL_BITS'(1);
                    sum_next  = '0;
                    fill_next = '0;
                    wr_next   = '0;
                end else if (in_beat) begin
                    x_next   = s_data.sample;
                    end_next = s_data.row_end;
                    ram_re   = 1'b1;
                end
            end
            ST_UPDATE: begin
                ram_we    = 1'b1;
                sum_next  = sum_reg + SUM_BITS'(x_reg)
                          - (drop_old ? SUM_BITS'(signed'(ram_rdata)) : '0);
                fill_next = fill_inc;
                if (end_reg) begin
                    j_next = run_cnt - WL_BITS'(1);
                end else begin
                    wr_next = wr_inc;
                end
            end
            ST_START: begin
                div_start = 1'b1;
            end
            ST_DIV: begin
            end
            ST_LOAD: begin
                ram_raddr = back_slot(wr_reg, j_reg + h_reg);
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_next.average     = SAMPLE_BITS'(div_quot);
                    out_next.row_last    = end_reg && (j_reg == '0);
                    out_next.last_of_run = !end_reg || (j_reg == '0);
                    if (end_reg) begin
                        if (j_reg == '0) begin
                            sum_next  = '0;
                            fill_next = '0;
                            wr_next   = '0;
                        end else if (drop_run) begin
                            ram_re = 1'b1;
                        end else begin
                            j_next = j_reg - WL_BITS'(1);
                        end
                    end
                end
            end
            ST_DROP: begin
                sum_next = sum_reg - SUM_BITS'(signed'(ram_rdata));
                j_next   = j_reg - WL_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== src/rma_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row moving average - port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "row_moving_average_core_macros.svh"

module rma_checker import rma_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     cfg_valid,
    input logic     cfg_ready,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input rma_out_t m_data
);

    // stalled result beat holds
    `RMA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // the last position of a row closes the flush
    `RMA_ASSERT_IMP(a_row_last_ends_run, aclk, aresetn, m_valid && m_data.row_last, m_data.last_of_run, "row_last without last_of_run")

    // no new beat or config while a flush is still running
    `RMA_ASSERT_IMP(a_run_blocks_input, aclk, aresetn, m_valid && !m_data.last_of_run, !s_ready && !cfg_ready, "ready during row-end flush")

    // one sample in work at a time
    `RMA_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after a beat")

endmodule

bind row_moving_average_core rma_checker u_rma_checker (.*);
